// ===== hw/rtl/sec_pkg.sv =====
// Shared types, codes and constants of the serial EEPROM command responder.
package sec_pkg;

  // Default sizes; the top level takes these as parameter defaults.
  localparam int MEM_BYTES_DEF   = 2048;
  localparam int FRAME_BYTES_DEF = 10;

  // A block is always eight bytes in this protocol.
  localparam int BLOCK_BYTES = 8;
  localparam int IDX_W       = $clog2(BLOCK_BYTES);

  // Byte positions inside a frame.
  localparam int CMD_POS     = 0;
  localparam int BLK_POS     = 1;
  localparam int WR_DATA_POS = 2;

  // Minimum frame lengths per command.
  localparam int LEN_INFO  = 1;
  localparam int LEN_READ  = 2;
  localparam int LEN_WRITE = WR_DATA_POS + BLOCK_BYTES;

  // Command codes.
  localparam logic [7:0] CMD_INFO  = 8'h00;
  localparam logic [7:0] CMD_READ  = 8'h04;
  localparam logic [7:0] CMD_WRITE = 8'h05;
  localparam logic [7:0] CMD_RESET = 8'hFF;

  // Identity reply and fill values.
  localparam logic [15:0] TYPE_SMALL       = 16'h0080;
  localparam logic [15:0] TYPE_LARGE       = 16'h00C0;
  localparam logic [7:0]  STATUS_BYTE      = 8'h00;
  localparam logic [7:0]  FILL_BYTE        = 8'hA1;
  localparam logic [7:0]  SMALL_BLOCK_MASK = 8'h3F;

  // Positions of the three bytes of the identity reply.
  localparam logic [IDX_W-1:0] INFO_POS_HI     = IDX_W'(0);
  localparam logic [IDX_W-1:0] INFO_POS_LO     = IDX_W'(1);
  localparam logic [IDX_W-1:0] INFO_POS_STATUS = IDX_W'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INFO_LOAD,
    ST_INFO_SEND,
    ST_RD_REQ,
    ST_RD_LOAD,
    ST_RD_SEND,
    ST_WR
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic clear_idx;
    logic inc_idx;
    logic mem_rd;
    logic mem_wr;
    logic load_info;
    logic load_mem;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [7:0] cmd;
    logic       len_info;
    logic       len_read;
    logic       len_write;
    logic       idx_last;
    logic       tx_last;
  } dp_status_t;

endpackage

// ===== hw/rtl/sec_ifs.sv =====
// Valid/ready channel interfaces for received frame bytes and reply bytes.
interface sec_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface sec_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       tx_last;

  modport source (output valid, output tx_byte, output tx_last, input ready);
  modport sink   (input valid, input tx_byte, input tx_last, output ready);
endinterface

// ===== hw/rtl/serial_eeprom_command_responder.sv =====
// Top level: serial EEPROM command responder, controller plus datapath.
// Timing: frame bytes are taken only while idle. After the frame-ending item, an identity
// reply goes through decode, info load and info send, and a read through decode, read request,
// read load and read send; each read byte passes the single memory port (address, registered
// read, reply register). Send states wait for tx.ready; a write stores the whole block.
// Reset (rst, synchronous): the size selects the small device, the frame is empty and every
// memory block reads as 0xA1 through per-block valid bits, so no clearing pass is needed.
module serial_eeprom_command_responder #(
  parameter int MEM_BYTES   = sec_pkg::MEM_BYTES_DEF,
  parameter int FRAME_BYTES = sec_pkg::FRAME_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_data,
  sec_rx_if.sink    rx,
  sec_tx_if.source  tx
);

  // The controller sequences one frame at a time: it takes bytes only while idle,
  // decodes the command once the frame ends, and then walks the reply or the write.
  sec_pkg::dp_cmd_t    cmd;
  sec_pkg::dp_status_t status;
  logic                in_ready;
  logic                out_valid;
  logic [7:0]          tx_byte;
  logic                tx_last;

  sec_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (rx.valid),
    .in_frame_end (rx.frame_end),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (tx.ready),
    .status       (status),
    .cmd          (cmd)
  );

  // The datapath holds the frame bytes, the memory and the reply register.
  sec_datapath #(
    .MEM_BYTES   (MEM_BYTES),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .rx_byte   (rx.rx_byte),
    .frame_end (rx.frame_end),
    .cmd       (cmd),
    .status    (status),
    .tx_byte   (tx_byte),
    .tx_last   (tx_last)
  );

  assign rx.ready   = in_ready;
  assign tx.valid   = out_valid;
  assign tx.tx_byte = tx_byte;
  assign tx.tx_last = tx_last;

  // The block never takes a new item while a reply byte is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(rx.ready && tx.valid))
    else $error("input ready while a reply item is offered");

  // A frame-ending item stops intake for at least the decode cycle.
  a_decode_stall: assert property (@(posedge clk) disable iff (rst)
    (rx.valid && rx.ready && rx.frame_end) |=> !rx.ready)
    else $error("input taken right after a frame end");

  // Once the final reply item is taken, the block returns to intake.
  a_reply_done: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && tx.ready && tx.tx_last) |=> rx.ready)
    else $error("block did not return to idle after the last reply item");

endmodule

// ===== hw/rtl/sec_ctrl.sv =====
// Controller state machine of the serial EEPROM command responder.
module sec_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_frame_end,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  sec_pkg::dp_status_t status,
  output sec_pkg::dp_cmd_t    cmd
);

  sec_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sec_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      sec_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid && in_frame_end) begin
          state_next = sec_pkg::ST_DECODE;
        end
      end
      sec_pkg::ST_DECODE: begin
        cmd.clear_idx = 1'b1;
        unique case (status.cmd) inside
          sec_pkg::CMD_INFO, sec_pkg::CMD_RESET: begin
            state_next = status.len_info ? sec_pkg::ST_INFO_LOAD : sec_pkg::ST_IDLE;
          end
          sec_pkg::CMD_READ: begin
            state_next = status.len_read ? sec_pkg::ST_RD_REQ : sec_pkg::ST_IDLE;
          end
          sec_pkg::CMD_WRITE: begin
            state_next = status.len_write ? sec_pkg::ST_WR : sec_pkg::ST_IDLE;
          end
          default: begin
            state_next = sec_pkg::ST_IDLE;
          end
        endcase
      end
      sec_pkg::ST_INFO_LOAD: begin
        cmd.load_info = 1'b1;
        state_next    = sec_pkg::ST_INFO_SEND;
      end
      sec_pkg::ST_INFO_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.tx_last) begin
            state_next = sec_pkg::ST_IDLE;
          end else begin
            cmd.inc_idx = 1'b1;
            state_next  = sec_pkg::ST_INFO_LOAD;
          end
        end
      end
      sec_pkg::ST_RD_REQ: begin
        cmd.mem_rd = 1'b1;
        state_next = sec_pkg::ST_RD_LOAD;
      end
      sec_pkg::ST_RD_LOAD: begin
        cmd.load_mem = 1'b1;
        state_next   = sec_pkg::ST_RD_SEND;
      end
      sec_pkg::ST_RD_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.tx_last) begin
            state_next = sec_pkg::ST_IDLE;
          end else begin
            cmd.inc_idx = 1'b1;
            state_next  = sec_pkg::ST_RD_REQ;
          end
        end
      end
      sec_pkg::ST_WR: begin
        cmd.mem_wr = 1'b1;
        if (status.idx_last) begin
          state_next = sec_pkg::ST_IDLE;
        end else begin
          cmd.inc_idx = 1'b1;
        end
      end
      default: begin
        state_next = sec_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/sec_datapath.sv =====
// Datapath: frame buffer, byte memory with per-block valid bits, reply register.
module sec_datapath #(
  parameter int MEM_BYTES   = sec_pkg::MEM_BYTES_DEF,
  parameter int FRAME_BYTES = sec_pkg::FRAME_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_data,
  input  logic [7:0]          rx_byte,
  input  logic                frame_end,
  input  sec_pkg::dp_cmd_t    cmd,
  output sec_pkg::dp_status_t status,
  output logic [7:0]          tx_byte,
  output logic                tx_last
);

  // MEM_BYTES is a power of two, so the byte address wraps by truncation.
  localparam int ROW_COUNT = MEM_BYTES / sec_pkg::BLOCK_BYTES;
  localparam int ROW_W     = $clog2(ROW_COUNT);
  localparam int ADDR_W    = $clog2(MEM_BYTES);
  localparam int CNT_W     = $clog2(FRAME_BYTES + 1);
  localparam int FI_W      = $clog2(FRAME_BYTES);
  localparam int IDX_W     = sec_pkg::IDX_W;

  logic                 large_size;
  logic [7:0]           frame_store [FRAME_BYTES];
  logic [CNT_W-1:0]     frame_count;
  logic [CNT_W-1:0]     count_inc;
  logic [CNT_W-1:0]     frame_len;
  logic                 has_room;
  logic [IDX_W-1:0]     idx;
  logic [7:0]           blk_masked;
  logic [ROW_W-1:0]     row;
  logic [ADDR_W-1:0]    addr;
  logic [FI_W-1:0]      wr_pos;
  logic [7:0]           mem [MEM_BYTES];
  logic [7:0]           mem_q;
  logic [ROW_COUNT-1:0] row_valid;
  logic                 row_valid_q;
  logic [15:0]          dev_type;

  always_ff @(posedge clk) begin
    if (rst) begin
      large_size <= 1'b0;
    end else if (cfg_we) begin
      large_size <= cfg_data;
    end
  end

  // Frame capture; the count saturates so surplus bytes are dropped.
  assign has_room  = frame_count < CNT_W'(FRAME_BYTES);
  assign count_inc = has_room ? frame_count + CNT_W'(1) : frame_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
    end else if (cmd.capture) begin
      frame_count <= frame_end ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      if (has_room) begin
        frame_store[frame_count[FI_W-1:0]] <= rx_byte;
      end
      if (frame_end) begin
        frame_len <= count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_idx) begin
      idx <= '0;
    end else if (cmd.inc_idx) begin
      idx <= idx + IDX_W'(1);
    end
  end

  // Block addressing: the small device only sees six block bits.
  assign blk_masked = large_size ? frame_store[sec_pkg::BLK_POS]
                                 : (frame_store[sec_pkg::BLK_POS] & sec_pkg::SMALL_BLOCK_MASK);
  assign row    = blk_masked[ROW_W-1:0];
  assign addr   = {row, idx};
  assign wr_pos = FI_W'(sec_pkg::WR_DATA_POS) + FI_W'(idx);

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr] <= frame_store[wr_pos];
    end
    if (cmd.mem_rd) begin
      mem_q       <= mem[addr];
      row_valid_q <= row_valid[row];
    end
  end

  // A block never written reads as the fill byte; writes always cover a whole block.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.mem_wr) begin
      row_valid[row] <= 1'b1;
    end
  end

  assign dev_type = large_size ? sec_pkg::TYPE_LARGE : sec_pkg::TYPE_SMALL;

  always_ff @(posedge clk) begin
    if (cmd.load_info) begin
      case (idx)
        sec_pkg::INFO_POS_HI: tx_byte <= dev_type[15:8];
        sec_pkg::INFO_POS_LO: tx_byte <= dev_type[7:0];
        default:              tx_byte <= sec_pkg::STATUS_BYTE;
      endcase
      tx_last <= (idx == sec_pkg::INFO_POS_STATUS);
    end else if (cmd.load_mem) begin
      tx_byte <= row_valid_q ? mem_q : sec_pkg::FILL_BYTE;
      tx_last <= (idx == IDX_W'(sec_pkg::BLOCK_BYTES - 1));
    end
  end

  assign status.cmd       = frame_store[sec_pkg::CMD_POS];
  assign status.len_info  = frame_len >= CNT_W'(sec_pkg::LEN_INFO);
  assign status.len_read  = frame_len >= CNT_W'(sec_pkg::LEN_READ);
  assign status.len_write = frame_len >= CNT_W'(sec_pkg::LEN_WRITE);
  assign status.idx_last  = (idx == IDX_W'(sec_pkg::BLOCK_BYTES - 1));
  assign status.tx_last   = tx_last;

endmodule
